FILE: sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// shared types and default constants of the triangle face normal unit
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int unsigned COORD_BITS_DEF       = 16;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;
  localparam int unsigned FIELD_W              = 16;
  localparam int unsigned OUT_W                = 16;

  // one triangle, three vertices in q7.8
  typedef struct packed {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] first_z;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] second_z;
    logic signed [FIELD_W-1:0] third_x;
    logic signed [FIELD_W-1:0] third_y;
    logic signed [FIELD_W-1:0] third_z;
  } tfn_in_t;

  // unit normal in q1.14 plus degenerate flag
  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    degenerate;
  } tfn_out_t;

endpackage

FILE: sv/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// edge vectors, partial products and cross product, three register stages
// ----------------------------------------------------------------------------
module tfn_cross #(
  parameter int unsigned CW = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  tfn_pkg::tfn_in_t           tri_i,
  output logic                       valid_o,
  output logic [2:0]                 neg_o,
  output logic [2:0][2*(CW+1)-1:0]   mag_o
);
  import tfn_pkg::*;

  localparam int unsigned EW = CW + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned XW = PW + 1;

  logic signed [CW-1:0] v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z;
  logic signed [EW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [PW-1:0] p_q [6];
  logic signed [XW-1:0] n_c [3];
  logic [2:0] neg_d;
  logic [2:0][PW-1:0] mag_d;
  logic [2:0] vld_q;

  // only the low coordinate bits count, sign-extended
  assign v0x = CW'(tri_i.first_x);
  assign v0y = CW'(tri_i.first_y);
  assign v0z = CW'(tri_i.first_z);
  assign v1x = CW'(tri_i.second_x);
  assign v1y = CW'(tri_i.second_y);
  assign v1z = CW'(tri_i.second_z);
  assign v2x = CW'(tri_i.third_x);
  assign v2y = CW'(tri_i.third_y);
  assign v2z = CW'(tri_i.third_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= EW'(v1x) - EW'(v0x);
    ay_q <= EW'(v1y) - EW'(v0y);
    az_q <= EW'(v1z) - EW'(v0z);
    bx_q <= EW'(v2x) - EW'(v0x);
    by_q <= EW'(v2y) - EW'(v0y);
    bz_q <= EW'(v2z) - EW'(v0z);
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= ay_q * bz_q;
    p_q[1] <= by_q * az_q;
    p_q[2] <= az_q * bx_q;
    p_q[3] <= bz_q * ax_q;
    p_q[4] <= ax_q * by_q;
    p_q[5] <= bx_q * ay_q;
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_c[l]   = XW'(p_q[2*l]) - XW'(p_q[2*l+1]);
      neg_d[l] = n_c[l][XW-1];
      mag_d[l] = n_c[l][XW-1] ? PW'(-n_c[l]) : PW'(n_c[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    neg_o <= neg_d;
    mag_o <= mag_d;
  end

  assign valid_o = vld_q[2];

endmodule

FILE: sv/tfn_square.sv
// ----------------------------------------------------------------------------
// tfn_square
// squares of the normal components and their sum, three register stages
// ----------------------------------------------------------------------------
module tfn_square #(
  parameter int unsigned NW = 2 * (tfn_pkg::COORD_BITS_DEF + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [2:0]             neg_i,
  input  logic [2:0][NW-1:0]     mag_i,
  output logic                   valid_o,
  output logic [2:0]             neg_o,
  output logic [2:0][2*NW-1:0]   sq_o,
  output logic [2*NW+1:0]        sum_o
);
  import tfn_pkg::*;

  localparam int unsigned H   = NW / 2;
  localparam int unsigned SQW = 2 * NW;
  localparam int unsigned SW  = SQW + 2;

  logic [2:0][2*H-1:0] hh_q, hl_q, ll_q;
  logic [2:0][SQW-1:0] sq_q;
  logic [2:0]          neg1_q, neg2_q;
  logic [2:0]          vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // half-width partial products
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      hh_q[l] <= mag_i[l][NW-1:H] * mag_i[l][NW-1:H];
      hl_q[l] <= mag_i[l][NW-1:H] * mag_i[l][H-1:0];
      ll_q[l] <= mag_i[l][H-1:0] * mag_i[l][H-1:0];
    end
    neg1_q <= neg_i;
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      sq_q[l] <= (SQW'(hh_q[l]) << (2 * H)) + (SQW'(hl_q[l]) << (H + 1)) + SQW'(ll_q[l]);
    end
    neg2_q <= neg1_q;
  end

  always_ff @(posedge clk_i) begin
    sum_o <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    sq_o  <= sq_q;
    neg_o <= neg2_q;
  end

  assign valid_o = vld_q[2];

endmodule

FILE: sv/tfn_div_stage.sv
// ----------------------------------------------------------------------------
// tfn_div_stage
// one quotient bit of the exact normalising divide, all three lanes
// ----------------------------------------------------------------------------
module tfn_div_stage #(
  parameter int unsigned SW  = 70,
  parameter int unsigned DW  = 100,
  parameter int unsigned QW  = 15,
  parameter int unsigned BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic                 degen_i,
  input  logic [2:0]           neg_i,
  input  logic [SW-1:0]        sum_i,
  input  logic [2:0][DW-1:0]   rem_i,
  input  logic [2:0][DW-1:0]   acc_i,
  input  logic [2:0][QW-1:0]   quo_i,
  output logic                 valid_o,
  output logic                 degen_o,
  output logic [2:0]           neg_o,
  output logic [SW-1:0]        sum_o,
  output logic [2:0][DW-1:0]   rem_o,
  output logic [2:0][DW-1:0]   acc_o,
  output logic [2:0][QW-1:0]   quo_o
);
  import tfn_pkg::*;

  logic [2:0][DW-1:0] cand;
  logic [2:0][DW-1:0] rem_d, acc_d;
  logic [2:0][QW-1:0] quo_d;
  logic               valid_q;

  // rem holds n^2*2^2f - q^2*s, acc holds q*s
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cand[l]  = (acc_i[l] << (BIT + 1)) + (DW'(sum_i) << (2 * BIT));
      rem_d[l] = rem_i[l];
      acc_d[l] = acc_i[l];
      quo_d[l] = quo_i[l];
      if (cand[l] <= rem_i[l]) begin
        rem_d[l]      = rem_i[l] - cand[l];
        acc_d[l]      = acc_i[l] + (DW'(sum_i) << BIT);
        quo_d[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o   <= rem_d;
    acc_o   <= acc_d;
    quo_o   <= quo_d;
    sum_o   <= sum_i;
    neg_o   <= neg_i;
    degen_o <= degen_i;
  end

  assign valid_o = valid_q;

endmodule

FILE: sv/triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// unit face normal of a triangle, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   a triangle beat (three q7.8 vertices on tri_i) is taken on any clock edge
//   with start_i high; busy_o is always low because every stage moves on each
//   cycle, so one triangle can enter per clock
//   the result beat (q1.14 unit normal and degenerate flag) shows on result_o
//   for exactly one cycle, marked by done_o; results leave in input order
//   throughput: one triangle per cycle; the divide chain has one register
//   stage per quotient bit
//   stages: edges, products, cross product, partial squares, squares, sum,
//   then one bit of the exact quotient per stage, then the output register
//   a zero cross product gives a zero normal with degenerate set
//   reset clears only the valid bits; no result leaves after reset until a
//   new triangle has passed the whole pipe
//   the receiver cannot stall, so no back-pressure path exists
// ----------------------------------------------------------------------------
module triangle_face_normal_unit #(
  parameter int unsigned COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tfn_pkg::tfn_in_t  tri_i,
  output logic              done_o,
  output tfn_pkg::tfn_out_t result_o
);
  import tfn_pkg::*;

  localparam int unsigned F    = NORMAL_FRAC_BITS;
  localparam int unsigned EW   = COORD_BITS + 1;
  localparam int unsigned NW   = 2 * EW;
  localparam int unsigned SQW  = 2 * NW;
  localparam int unsigned SW   = SQW + 2;
  localparam int unsigned DW   = SW + 2 * F + 2;
  localparam int unsigned QW   = F + 1;
  localparam int unsigned NST  = F + 1;
  localparam int unsigned LAT  = F + 8;

  // cross product side
  logic               x_valid;
  logic [2:0]         x_neg;
  logic [2:0][NW-1:0] x_mag;

  // squares side
  logic                s_valid;
  logic [2:0]          s_neg;
  logic [2:0][SQW-1:0] s_sq;
  logic [SW-1:0]       s_sum;

  // divide chain, entry k feeds stage k
  logic [NST:0]                 c_valid;
  logic [NST:0]                 c_degen;
  logic [NST:0][2:0]            c_neg;
  logic [NST:0][SW-1:0]         c_sum;
  logic [NST:0][2:0][DW-1:0]    c_rem;
  logic [NST:0][2:0][DW-1:0]    c_acc;
  logic [NST:0][2:0][QW-1:0]    c_quo;

  logic     done_q;
  tfn_out_t result_q, result_d;

  // every stage advances each cycle
  assign busy_o = 1'b0;

  tfn_cross #(
    .CW (COORD_BITS)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .tri_i   (tri_i),
    .valid_o (x_valid),
    .neg_o   (x_neg),
    .mag_o   (x_mag)
  );

  tfn_square #(
    .NW (NW)
  ) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x_valid),
    .neg_i   (x_neg),
    .mag_i   (x_mag),
    .valid_o (s_valid),
    .neg_o   (s_neg),
    .sq_o    (s_sq),
    .sum_o   (s_sum)
  );

  // seed the remainder with n^2 scaled by the output fraction
  always_comb begin
    c_valid[0] = s_valid;
    c_degen[0] = (s_sum == '0);
    c_neg[0]   = s_neg;
    c_sum[0]   = s_sum;
    for (int l = 0; l < 3; l++) begin
      c_rem[0][l] = DW'(s_sq[l]) << (2 * F);
      c_acc[0][l] = '0;
      c_quo[0][l] = '0;
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_div
    tfn_div_stage #(
      .SW  (SW),
      .DW  (DW),
      .QW  (QW),
      .BIT (F - k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k]),
      .degen_i (c_degen[k]),
      .neg_i   (c_neg[k]),
      .sum_i   (c_sum[k]),
      .rem_i   (c_rem[k]),
      .acc_i   (c_acc[k]),
      .quo_i   (c_quo[k]),
      .valid_o (c_valid[k+1]),
      .degen_o (c_degen[k+1]),
      .neg_o   (c_neg[k+1]),
      .sum_o   (c_sum[k+1]),
      .rem_o   (c_rem[k+1]),
      .acc_o   (c_acc[k+1]),
      .quo_o   (c_quo[k+1])
    );
  end

  // apply sign, wrap to the output width, force zero when degenerate
  always_comb begin
    logic signed [OUT_W-1:0] ux, uy, uz;
    ux = OUT_W'(c_quo[NST][0]);
    uy = OUT_W'(c_quo[NST][1]);
    uz = OUT_W'(c_quo[NST][2]);
    result_d.unit_x     = c_neg[NST][0] ? -ux : ux;
    result_d.unit_y     = c_neg[NST][1] ? -uy : uy;
    result_d.unit_z     = c_neg[NST][2] ? -uz : uz;
    result_d.degenerate = c_degen[NST];
    if (c_degen[NST]) begin
      result_d.unit_x = '0;
      result_d.unit_y = '0;
      result_d.unit_z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c_valid[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // a degenerate beat carries a zero normal
  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.degenerate |->
      result_o.unit_x == '0 && result_o.unit_y == '0 && result_o.unit_z == '0)
    else $error("degenerate result with nonzero normal");

  // every result beat comes from a matching start that went through the pipe
  a_done_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result beat without matching start");

  // a beat leaving the last divide stage shows as done_o in the next cycle
  a_chain_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[NST] |=> done_o)
    else $error("divide chain beat lost at output");

endmodule

FILE: verif/tfn_normal_checker.sv
// ----------------------------------------------------------------------------
// tfn_normal_checker
// watches the triangle and result beats, predicts each unit normal exactly
// and compares it field by field with the result beat
// ----------------------------------------------------------------------------
module tfn_normal_checker #(
  parameter int unsigned COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  tfn_pkg::tfn_in_t  tri_i,
  input  logic              done_i,
  input  tfn_pkg::tfn_out_t result_i,
  output int                pending_o,
  output int                errors_o
);
  import tfn_pkg::*;

  tfn_out_t normals_due[$];

  // sign-extend from the top used coordinate bit
  function automatic longint vertex_coord(logic [FIELD_W-1:0] raw);
    longint v;
    v = longint'(raw & ((64'd1 << COORD_BITS) - 1));
    if (v[COORD_BITS-1]) v = v - (longint'(1) << COORD_BITS);
    return v;
  endfunction

  function automatic logic [127:0] mag_of(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // exact truncated quotient |n_c| * 2^frac / sqrt(s), signed, wrapped to 16 bits
  function automatic logic [OUT_W-1:0] unit_part(longint nc, logic [127:0] s);
    logic [127:0] m, rhs, trial;
    logic [127:0] q;
    q = '0;
    m = mag_of(nc);
    rhs = (m * m) << (2 * NORMAL_FRAC_BITS);
    for (int b = NORMAL_FRAC_BITS; b >= 0; b--) begin
      trial = q | (128'd1 << b);
      if (trial * trial * s <= rhs) q = trial;
    end
    return (nc < 0) ? OUT_W'(-q) : OUT_W'(q);
  endfunction

  function automatic tfn_out_t face_normal(tfn_in_t t);
    longint ax, ay, az, bx, by, bz, nx, ny, nz;
    logic [127:0] s;
    tfn_out_t r;
    ax = vertex_coord(t.second_x) - vertex_coord(t.first_x);
    ay = vertex_coord(t.second_y) - vertex_coord(t.first_y);
    az = vertex_coord(t.second_z) - vertex_coord(t.first_z);
    bx = vertex_coord(t.third_x) - vertex_coord(t.first_x);
    by = vertex_coord(t.third_y) - vertex_coord(t.first_y);
    bz = vertex_coord(t.third_z) - vertex_coord(t.first_z);
    nx = ay * bz - by * az;
    ny = az * bx - bz * ax;
    nz = ax * by - bx * ay;
    s = mag_of(nx) * mag_of(nx) + mag_of(ny) * mag_of(ny) + mag_of(nz) * mag_of(nz);
    r = '0;
    if (s == 0) begin
      r.degenerate = 1'b1;
    end else begin
      r.unit_x = unit_part(nx, s);
      r.unit_y = unit_part(ny, s);
      r.unit_z = unit_part(nz, s);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  initial errors_o = 0;
  assign pending_o = normals_due.size();

  always @(posedge clk_i) begin
    tfn_out_t want;
    if (rst_ni && start_i && !busy_i) normals_due.push_back(face_normal(tri_i));
    if (rst_ni && done_i) begin
      if (normals_due.size() == 0) begin
        report_mismatch("result beat with nothing due", 1, 0);
      end else begin
        want = normals_due.pop_front();
        if (result_i.unit_x !== want.unit_x)
          report_mismatch("unit_x", result_i.unit_x, want.unit_x);
        if (result_i.unit_y !== want.unit_y)
          report_mismatch("unit_y", result_i.unit_y, want.unit_y);
        if (result_i.unit_z !== want.unit_z)
          report_mismatch("unit_z", result_i.unit_z, want.unit_z);
        if (result_i.degenerate !== want.degenerate)
          report_mismatch("degenerate", result_i.degenerate, want.degenerate);
      end
    end
  end

endmodule

FILE: verif/tb_triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_unit
// drives directed and random triangles with random gaps into the face normal
// unit; the checker beside it predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_unit;
  import tfn_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 60;  // more than the pipe depth

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  tfn_in_t  tri_i = '0;
  logic     done_o;
  tfn_out_t result_o;
  int       pending;
  int       errors;
  int       cycles = 0;

  triangle_face_normal_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .tri_i   (tri_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  tfn_normal_checker checker_u (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_i   (busy_o),
    .tri_i    (tri_i),
    .done_i   (done_o),
    .result_i (result_o),
    .pending_o(pending),
    .errors_o (errors)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hold the beat until it is taken; start stays high on return so that
  // back-to-back beats never drop it
  task automatic send_triangle(tfn_in_t t);
    @(negedge clk_i);
    start_i <= 1'b1;
    tri_i   <= t;
    while (busy_o) @(negedge clk_i);
  endtask

  // idle gap: mostly none or short, now and then long
  task automatic random_gap();
    int n;
    case ($urandom_range(9))
      0, 1, 2, 3: n = 0;
      4, 5, 6, 7: n = $urandom_range(3, 1);
      8:          n = $urandom_range(12, 4);
      default:    n = $urandom_range(45, 13);
    endcase
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      tri_i   <= tfn_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end
  endtask

  function automatic tfn_in_t make_tri(int fx, int fy, int fz, int sx, int sy, int sz,
                                       int tx, int ty, int tz);
    tfn_in_t t;
    t.first_x  = FIELD_W'(fx); t.first_y  = FIELD_W'(fy); t.first_z  = FIELD_W'(fz);
    t.second_x = FIELD_W'(sx); t.second_y = FIELD_W'(sy); t.second_z = FIELD_W'(sz);
    t.third_x  = FIELD_W'(tx); t.third_y  = FIELD_W'(ty); t.third_z  = FIELD_W'(tz);
    return t;
  endfunction

  function automatic int small_coord();
    return $urandom_range(512) - 256;
  endfunction

  function automatic tfn_in_t random_tri();
    tfn_in_t t;
    int fx, fy, fz, dx, dy, dz, k;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // full range, every bit of every field toggles
        t = tfn_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      end
      4, 5: begin
        // modest mesh-like triangle around a random point
        fx = $urandom_range(65535) - 32768;
        fy = $urandom_range(65535) - 32768;
        fz = $urandom_range(65535) - 32768;
        t = make_tri(fx, fy, fz, fx + small_coord(), fy + small_coord(), fz + small_coord(),
                     fx + small_coord(), fy + small_coord(), fz + small_coord());
      end
      6, 7: begin
        // collinear or coincident points, the degenerate case
        fx = small_coord(); fy = small_coord(); fz = small_coord();
        dx = small_coord() / 4; dy = small_coord() / 4; dz = small_coord() / 4;
        k = $urandom_range(6) - 3;
        t = make_tri(fx, fy, fz, fx + dx, fy + dy, fz + dz,
                     fx + k * dx, fy + k * dy, fz + k * dz);
      end
      default: begin
        // triangle in an axis plane, normal along one axis
        fx = small_coord(); fy = small_coord(); fz = small_coord();
        dx = small_coord(); dy = small_coord();
        case ($urandom_range(2))
          0:       t = make_tri(fx, fy, fz, fx + dx, fy, fz, fx, fy + dy, fz);
          1:       t = make_tri(fx, fy, fz, fx, fy + dx, fz, fx, fy, fz + dy);
          default: t = make_tri(fx, fy, fz, fx, fy, fz + dx, fx + dy, fy, fz);
        endcase
      end
    endcase
    return t;
  endfunction

  initial begin
    tfn_in_t directed_q[$];
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: all zero, axis normals (both ways for x and z), extremes, collinear
    directed_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
    directed_q.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
    directed_q.push_back(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
    directed_q.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
    directed_q.push_back(make_tri(0, 0, 0, 0, 0, 256, 0, 256, 0));
    directed_q.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                  -32768, 32767, -32768));
    directed_q.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                  32767, -32768, 32767));
    directed_q.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                                  -32768, 32767, 32767));
    directed_q.push_back(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                                  32767, 32767, -32768));
    directed_q.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                  -32768, -32768, -32768));
    directed_q.push_back(make_tri(-32768, 0, 32767, 32767, 0, -32768, -32768, 0, 32767));
    directed_q.push_back(make_tri(0, 0, 0, 1, 0, 0, 2, 0, 0));
    directed_q.push_back(make_tri(5, 5, 5, 5, 5, 5, 9, -3, 7));
    directed_q.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_q.push_back(make_tri(0, 0, 0, 256, 256, 0, 0, 256, 256));
    directed_q.push_back(make_tri(0, 0, 0, 1, 2, 3, 4, 5, 7));
    directed_q.push_back(make_tri(-1, -1, -1, 32767, -32768, 1, -32768, 32767, 2));
    foreach (directed_q[i]) begin
      send_triangle(directed_q[i]);
      if ($urandom_range(1)) random_gap();
    end

    repeat (550) begin
      send_triangle(random_tri());
      random_gap();
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // drain, then allow for any stray late beat
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
